[hw/rtl/cst_pkg.sv]
// package: types, codes and sizes for the semaphore table
`timescale 1ns / 1ps
package cst_pkg;
	localparam int NUM_SEMS   = 16;
	localparam int NUM_TASKS  = 16;
	localparam int COUNT_BITS = 15;
	localparam int SEM_W      = $clog2(NUM_SEMS);
	localparam int TASK_W     = $clog2(NUM_TASKS);
	localparam int LINK_W     = 5;
	localparam logic [LINK_W-1:0] NO_TASK = 5'd31;
	localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
	localparam logic FIFO_ATTR = 1'b1;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_SIGNAL  = 3'd2,
		OP_WAIT    = 3'd3,
		OP_TWAIT   = 3'd4,
		OP_POLL    = 3'd5,
		OP_TIMEOUT = 3'd6,
		OP_REFER   = 3'd7
	} op_t;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_BADID  = 3'd1;
	localparam logic [2:0] ST_STATE  = 3'd2;
	localparam logic [2:0] ST_PARAM  = 3'd3;
	localparam logic [2:0] ST_NORES  = 3'd4;

	localparam logic [1:0] WC_GRANT   = 2'd0;
	localparam logic [1:0] WC_DELETED = 2'd1;
	localparam logic [1:0] WC_TIMEOUT = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  sem_id;
		logic [3:0]  task_id;
		logic [15:0] initial_count;
		logic [15:0] max_count;
		logic        attr_fifo;
		logic [31:0] ext_info;
		logic [15:0] timeout_ticks;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        caller_blocked;
		logic        arm_timer;
		logic [15:0] timer_ticks;
		logic        wake_valid;
		logic [3:0]  wake_task;
		logic [1:0]  wake_code;
		logic [14:0] count_out;
		logic        waiters_present;
		logic [31:0] ext_info_out;
		logic        last;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request
		logic exec;      // single-step operation
		logic walk;      // one delete step
		logic walk_init; // start delete walk at queue head
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_more; // delete has further waiters after this one
		logic is_walk;   // request starts a delete walk
	} sts_t;
endpackage

[hw/rtl/cst_if.sv]
// valid/ready channel interface
`timescale 1ns / 1ps
interface cst_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/cst_ctrl.sv]
// controller state machine for the semaphore table
`timescale 1ns / 1ps
module cst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output cst_pkg::cmd_t cmd,
	input  cst_pkg::sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_WALK = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   more_q, more_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		more_d  = more_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.is_walk) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK;
				end else begin
					cmd.exec = 1'b1;
					more_d   = 1'b0;
					state_d  = S_OUT;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				more_d   = sts.walk_more;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = more_q ? S_WALK : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			more_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			more_q  <= more_d;
		end
	end
endmodule

[hw/rtl/cst_dp.sv]
// datapath: semaphore table, wait queues and result register
`timescale 1ns / 1ps
module cst_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  cst_pkg::req_t  req,
	input  cst_pkg::cmd_t  cmd,
	output cst_pkg::sts_t  sts,
	output cst_pkg::rsp_t  rsp
);
	localparam int SN = cst_pkg::NUM_SEMS;
	localparam int TN = cst_pkg::NUM_TASKS;
	localparam int SW = cst_pkg::SEM_W;
	localparam int TW = cst_pkg::TASK_W;
	localparam int LW = cst_pkg::LINK_W;
	localparam int CB = cst_pkg::COUNT_BITS;

	logic [SN-1:0]         created_q;
	logic [CB-1:0]         count_q   [SN];
	logic [CB-1:0]         maximum_q [SN];
	logic [31:0]           info_q    [SN];
	logic [LW-1:0]         head_q    [SN];
	logic [LW-1:0]         tail_q    [SN];
	logic [LW-1:0]         next_q    [TN];
	logic [LW-1:0]         prev_q    [TN];
	logic [LW-1:0]         wsem_q    [TN];
	cst_pkg::req_t         req_q;
	cst_pkg::rsp_t         rsp_q;
	cst_pkg::rsp_t         rsp_d;
	logic [LW-1:0]         walk_q;

	logic          id_ok, task_ok;
	logic [SW-1:0] s;
	logic [TW-1:0] t;
	logic [LW-1:0] ts;
	logic [SW-1:0] tsi;
	logic [LW-1:0] hd;
	logic [TW-1:0] hdi, wk;
	logic [LW-1:0] wnext;

	assign id_ok   = (req_q.sem_id != 8'd0) && (32'(req_q.sem_id) < SN);
	assign s       = req_q.sem_id[SW-1:0];
	assign task_ok = 32'(req_q.task_id) < TN;
	assign t       = req_q.task_id[TW-1:0];
	assign ts      = wsem_q[t];
	assign tsi     = ts[SW-1:0];
	assign hd      = head_q[s];
	assign hdi     = hd[TW-1:0];
	assign wk      = walk_q[TW-1:0];
	assign wnext   = next_q[wk];

	assign sts.is_walk   = (cst_pkg::op_t'(req_q.operation) == cst_pkg::OP_DELETE) && id_ok
		&& created_q[s] && (32'(hd) < TN);
	assign sts.walk_more = 32'(wnext) < TN;
	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q <= '0;
			for (int i = 0; i < SN; i++) begin
				head_q[i] <= cst_pkg::NO_TASK;
				tail_q[i] <= cst_pkg::NO_TASK;
			end
			for (int i = 0; i < TN; i++) wsem_q[i] <= '0;
			walk_q <= cst_pkg::NO_TASK;
		end else if (cmd.walk) begin
			wsem_q[wk] <= '0;
			walk_q     <= wnext;
			if (!(32'(wnext) < TN)) begin
				head_q[s]    <= cst_pkg::NO_TASK;
				tail_q[s]    <= cst_pkg::NO_TASK;
				created_q[s] <= 1'b0;
				count_q[s]   <= '0;
			end
		end else if (cmd.exec) begin
			case (cst_pkg::op_t'(req_q.operation))
				cst_pkg::OP_TIMEOUT: begin
					if (task_ok && ts != '0 && 32'(ts) < SN) begin
						if (32'(prev_q[t]) < TN) next_q[prev_q[t][TW-1:0]] <= next_q[t];
						else head_q[tsi] <= next_q[t];
						if (32'(next_q[t]) < TN) prev_q[next_q[t][TW-1:0]] <= prev_q[t];
						else tail_q[tsi] <= prev_q[t];
						wsem_q[t] <= '0;
					end
				end
				cst_pkg::OP_CREATE: begin
					if (id_ok && !created_q[s] && !req_q.max_count[15]
						&& req_q.max_count != '0 && !req_q.initial_count[15]
						&& req_q.attr_fifo == cst_pkg::FIFO_ATTR) begin
						created_q[s] <= 1'b1;
						count_q[s]   <= (32'(req_q.initial_count) > 32'(cst_pkg::COUNT_TOP))
							? cst_pkg::COUNT_TOP : CB'(req_q.initial_count);
						maximum_q[s] <= (32'(req_q.max_count) > 32'(cst_pkg::COUNT_TOP))
							? cst_pkg::COUNT_TOP : CB'(req_q.max_count);
						info_q[s]    <= req_q.ext_info;
						head_q[s]    <= cst_pkg::NO_TASK;
						tail_q[s]    <= cst_pkg::NO_TASK;
					end
				end
				cst_pkg::OP_DELETE: begin
					if (id_ok && created_q[s]) begin
						head_q[s]    <= cst_pkg::NO_TASK;
						tail_q[s]    <= cst_pkg::NO_TASK;
						created_q[s] <= 1'b0;
						count_q[s]   <= '0;
					end
				end
				cst_pkg::OP_SIGNAL: begin
					if (id_ok && created_q[s]) begin
						if (32'(hd) < TN) begin
							if (32'(next_q[hdi]) < TN)
								prev_q[next_q[hdi][TW-1:0]] <= cst_pkg::NO_TASK;
							else tail_q[s] <= cst_pkg::NO_TASK;
							head_q[s]   <= next_q[hdi];
							wsem_q[hdi] <= '0;
						end else if (count_q[s] != cst_pkg::COUNT_TOP) begin
							count_q[s] <= count_q[s] + 1'b1;
						end
					end
				end
				cst_pkg::OP_WAIT, cst_pkg::OP_TWAIT: begin
					if (id_ok && created_q[s] && task_ok && ts == '0) begin
						if (count_q[s] != '0) begin
							count_q[s] <= count_q[s] - 1'b1;
						end else begin
							next_q[t] <= cst_pkg::NO_TASK;
							prev_q[t] <= tail_q[s];
							if (32'(tail_q[s]) < TN) next_q[tail_q[s][TW-1:0]] <= LW'(t);
							else head_q[s] <= LW'(t);
							tail_q[s] <= LW'(t);
							wsem_q[t] <= LW'(s);
						end
					end
				end
				cst_pkg::OP_POLL: begin
					if (id_ok && created_q[s] && count_q[s] != '0)
						count_q[s] <= count_q[s] - 1'b1;
				end
				default: ;
			endcase
		end else if (cmd.walk_init) begin
			walk_q <= hd;
		end
	end

	always_comb begin
		rsp_d = '0;
		if (cmd.walk) begin
			rsp_d.wake_valid = 1'b1;
			rsp_d.wake_task  = 4'(wk);
			rsp_d.wake_code  = cst_pkg::WC_DELETED;
			rsp_d.last       = !(32'(wnext) < TN);
		end else begin
			rsp_d.last = 1'b1;
			if (cst_pkg::op_t'(req_q.operation) == cst_pkg::OP_TIMEOUT) begin
				if (!task_ok) rsp_d.status = cst_pkg::ST_PARAM;
				else if (ts == '0 || !(32'(ts) < SN)) rsp_d.status = cst_pkg::ST_STATE;
				else begin
					rsp_d.wake_valid = 1'b1;
					rsp_d.wake_task  = req_q.task_id;
					rsp_d.wake_code  = cst_pkg::WC_TIMEOUT;
				end
			end else if (!id_ok) begin
				rsp_d.status = cst_pkg::ST_BADID;
			end else if (cst_pkg::op_t'(req_q.operation) == cst_pkg::OP_CREATE) begin
				if (created_q[s]) rsp_d.status = cst_pkg::ST_STATE;
				else if (req_q.max_count[15] || req_q.max_count == '0
					|| req_q.initial_count[15] || req_q.attr_fifo != cst_pkg::FIFO_ATTR)
					rsp_d.status = cst_pkg::ST_PARAM;
			end else if (!created_q[s]) begin
				rsp_d.status = cst_pkg::ST_STATE;
			end else begin
				case (cst_pkg::op_t'(req_q.operation))
					cst_pkg::OP_SIGNAL: begin
						if (32'(hd) < TN) begin
							rsp_d.wake_valid = 1'b1;
							rsp_d.wake_task  = 4'(hdi);
							rsp_d.wake_code  = cst_pkg::WC_GRANT;
						end
					end
					cst_pkg::OP_WAIT, cst_pkg::OP_TWAIT: begin
						if (!task_ok) rsp_d.status = cst_pkg::ST_PARAM;
						else if (ts != '0) rsp_d.status = cst_pkg::ST_STATE;
						else if (count_q[s] == '0) begin
							rsp_d.caller_blocked = 1'b1;
							if (cst_pkg::op_t'(req_q.operation) == cst_pkg::OP_TWAIT) begin
								rsp_d.arm_timer   = 1'b1;
								rsp_d.timer_ticks = req_q.timeout_ticks;
							end
						end
					end
					cst_pkg::OP_POLL: begin
						if (count_q[s] == '0) rsp_d.status = cst_pkg::ST_NORES;
					end
					cst_pkg::OP_REFER: begin
						rsp_d.count_out       = 15'(count_q[s]);
						rsp_d.waiters_present = 32'(hd) < TN;
						rsp_d.ext_info_out    = info_q[s];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk || cmd.exec) rsp_q <= rsp_d;
	end

	logic unused_max;
	assign unused_max = ^maximum_q[s];
endmodule

[hw/rtl/counting_semaphore_table_core.sv]
// top level of the counting semaphore table
// result word registered: request captured in idle, executed in exec, presented in out
// delete with waiters goes through exec, then walk and out for each released waiter,
//   one result word each
// one operation at a time; input ready only while idle
// reset clears created flags, queue heads/tails and task wait marks at once
`timescale 1ns / 1ps
module counting_semaphore_table_core (
	input  logic clk,
	input  logic arst_n,
	cst_if.sink   req,
	cst_if.source rsp
);
	cst_pkg::cmd_t cmd;
	cst_pkg::sts_t sts;

	cst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	cst_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.data),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp.data)
	);
endmodule
